// File: src/cau_pkg.sv
// shared types, widths and saturation helper for the complex arithmetic unit
`default_nettype none
package cau_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int CMD_W      = 3;

	// derived widths
	localparam int PW    = 2 * DATA_WIDTH;          // full product
	localparam int SW    = PW + 1;                  // signed sum of products
	localparam int RW    = PW + 1;                  // divider remainder
	localparam int SH    = DATA_WIDTH - FRAC_BITS;  // quotient headroom shift
	localparam int SHI_W = PW - FRAC_BITS;          // squared magnitude after shift

	localparam logic [SW-1:0] LIM_POS = {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [SW-1:0] LIM_NEG = LIM_POS + {{(SW-1){1'b0}}, 1'b1};
	localparam logic [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_MAG = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] word;
		logic                  ovf;
	} sat_t;

	// one word in flight through the iterative section
	typedef struct packed {
		cmd_t                  cmd;
		logic [DATA_WIDTH-1:0] e_re;
		logic [DATA_WIDTH-1:0] e_im;
		logic                  e_ovf;
		logic                  dz;
		logic                  neg_re;
		logic                  neg_im;
		logic                  sat_re;
		logic                  sat_im;
		logic [RW-1:0]         rem_re;
		logic [RW-1:0]         rem_im;
		logic [DATA_WIDTH-1:0] feed_re;
		logic [DATA_WIDTH-1:0] feed_im;
		logic [DATA_WIDTH-1:0] q_re;
		logic [DATA_WIDTH-1:0] q_im;
		logic [PW-1:0]         den;
		logic [PW-1:0]         sq_op;
		logic [PW-1:0]         sq_res;
		logic [SHI_W-1:0]      s_hi;
	} iter_t;

	// sign and magnitude to a saturated word
	function automatic sat_t sat_mag(input logic neg, input logic [SW-1:0] mag);
		sat_t r;
		r.ovf = 1'b0;
		if (!neg) begin
			if (mag > LIM_POS) begin
				r.word = WORD_MAX;
				r.ovf  = 1'b1;
			end else begin
				r.word = mag[DATA_WIDTH-1:0];
			end
		end else begin
			if (mag > LIM_NEG) begin
				r.word = WORD_MIN;
				r.ovf  = 1'b1;
			end else begin
				r.word = (~mag[DATA_WIDTH-1:0]) + {{(DATA_WIDTH-1){1'b0}}, 1'b1};
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: src/cau_in_if.sv
// input channel: command and two complex operands
`default_nettype none
interface cau_in_if;
	import cau_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      cmd;
	logic [DATA_WIDTH-1:0] a_re;
	logic [DATA_WIDTH-1:0] a_im;
	logic [DATA_WIDTH-1:0] b_re;
	logic [DATA_WIDTH-1:0] b_im;

	modport source (output valid, cmd, a_re, a_im, b_re, b_im, input ready);
	modport sink   (input valid, cmd, a_re, a_im, b_re, b_im, output ready);
endinterface
`default_nettype wire

// File: src/cau_out_if.sv
// output channel: complex result and flags
`default_nettype none
interface cau_out_if;
	import cau_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] res_re;
	logic [DATA_WIDTH-1:0] res_im;
	logic                  overflow;
	logic                  div_by_zero;

	modport source (output valid, res_re, res_im, overflow, div_by_zero, input ready);
	modport sink   (input valid, res_re, res_im, overflow, div_by_zero, output ready);
endinterface
`default_nettype wire

// File: src/complex_arithmetic_unit.sv
// complex arithmetic unit top level: add, subtract, multiply, divide, magnitude
// Usage:
//   in_ch carries one word per handshake: cmd plus operands a and b, signed Q16.16.
//   out_ch returns one word per input word, in order: res_re, res_im, overflow and
//   div_by_zero. Multiply and divide results truncate toward zero, magnitude gives
//   floor of the root in raw units, and every part saturates with overflow set.
//   A divide by zero returns zeros with div_by_zero set; unused codes return zeros.
// Timing:
//   from acceptance to the result on out_ch a word passes five front stages
//   (operand register, multipliers, product sums, magnitudes, divider setup), 32
//   stages of the unrolled divider and root, one bit each, and the output register.
//   One word is accepted every cycle while out_ch takes results.
// Reset:
//   arst_n clears every valid bit at once; nothing is in flight after reset.
// Stall:
//   the whole pipeline holds while a result waits on out_ch; in_ch.ready drops
//   in that cycle, so no word is lost or repeated.
`default_nettype none
module complex_arithmetic_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	cau_in_if.sink    in_ch,
	cau_out_if.source out_ch
);
	import cau_pkg::*;

	logic  en;
	logic  f_valid, i_valid;
	iter_t f_word, i_word;

	// whole pipeline advances unless a result is held
	assign en          = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	cau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_ch.valid),
		.in_cmd    (in_ch.cmd),
		.in_a_re   (in_ch.a_re),
		.in_a_im   (in_ch.a_im),
		.in_b_re   (in_ch.b_re),
		.in_b_im   (in_ch.b_im),
		.out_valid (f_valid),
		.out_word  (f_word)
	);

	cau_iter u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.in_word   (f_word),
		.out_valid (i_valid),
		.out_word  (i_word)
	);

	cau_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (i_valid),
		.in_word   (i_word),
		.out_valid (out_ch.valid),
		.out_re    (out_ch.res_re),
		.out_im    (out_ch.res_im),
		.out_ovf   (out_ch.overflow),
		.out_dz    (out_ch.div_by_zero)
	);

endmodule
`default_nettype wire

// File: src/cau_front.sv
// front stages: add/sub, products, sums, magnitudes, divider setup
`default_nettype none
module cau_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [cau_pkg::CMD_W-1:0]     in_cmd,
	input  wire logic [cau_pkg::DATA_WIDTH-1:0] in_a_re,
	input  wire logic [cau_pkg::DATA_WIDTH-1:0] in_a_im,
	input  wire logic [cau_pkg::DATA_WIDTH-1:0] in_b_re,
	input  wire logic [cau_pkg::DATA_WIDTH-1:0] in_b_im,
	output logic                               out_valid,
	output cau_pkg::iter_t                     out_word
);
	import cau_pkg::*;

	localparam int DW = DATA_WIDTH;

	// stage 1 registers
	logic                 v_s1;
	cmd_t                 cmd_s1;
	logic signed [DW-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	sat_t                 as_re_s1, as_im_s1;

	// stage 2 registers
	logic                 v_s2;
	cmd_t                 cmd_s2;
	sat_t                 as_re_s2, as_im_s2;
	logic signed [PW-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [PW-1:0] q_br_s2, q_bi_s2, q_ar_s2, q_ai_s2;

	// stage 3 registers
	logic                 v_s3;
	cmd_t                 cmd_s3;
	sat_t                 as_re_s3, as_im_s3;
	logic signed [SW-1:0] m_re_s3, m_im_s3, n_re_s3, n_im_s3;
	logic [PW-1:0]        den_s3, s_s3;

	// stage 4 registers
	logic                 v_s4;
	cmd_t                 cmd_s4;
	sat_t                 as_re_s4, as_im_s4;
	sat_t                 mul_re_s4, mul_im_s4;
	logic [PW-1:0]        nmag_re_s4, nmag_im_s4;
	logic                 neg_re_s4, neg_im_s4;
	logic [PW-1:0]        den_s4, s_s4;

	// stage 5 register
	logic                 v_s5;
	iter_t                w_s5;

	// add and subtract with saturation
	logic signed [DW:0] sum_re, sum_im;
	sat_t               as_re_c, as_im_c;

	always_comb begin
		if (in_cmd == CMD_SUB) begin
			sum_re = {in_a_re[DW-1], in_a_re} - {in_b_re[DW-1], in_b_re};
			sum_im = {in_a_im[DW-1], in_a_im} - {in_b_im[DW-1], in_b_im};
		end else begin
			sum_re = {in_a_re[DW-1], in_a_re} + {in_b_re[DW-1], in_b_re};
			sum_im = {in_a_im[DW-1], in_a_im} + {in_b_im[DW-1], in_b_im};
		end
		as_re_c.ovf  = sum_re[DW] != sum_re[DW-1];
		as_re_c.word = as_re_c.ovf ? (sum_re[DW] ? WORD_MIN : WORD_MAX) : sum_re[DW-1:0];
		as_im_c.ovf  = sum_im[DW] != sum_im[DW-1];
		as_im_c.word = as_im_c.ovf ? (sum_im[DW] ? WORD_MIN : WORD_MAX) : sum_im[DW-1:0];
	end

	// magnitudes of the sums of products
	logic [SW-1:0] mag_m_re, mag_m_im, mag_n_re, mag_n_im;

	always_comb begin
		mag_m_re = m_re_s3[SW-1] ? SW'(-m_re_s3) : SW'(m_re_s3);
		mag_m_im = m_im_s3[SW-1] ? SW'(-m_im_s3) : SW'(m_im_s3);
		mag_n_re = n_re_s3[SW-1] ? SW'(-n_re_s3) : SW'(n_re_s3);
		mag_n_im = n_im_s3[SW-1] ? SW'(-n_im_s3) : SW'(n_im_s3);
	end

	// divider setup and early result select
	iter_t w_c;

	always_comb begin
		w_c.cmd     = cmd_s4;
		w_c.dz      = (cmd_s4 == CMD_DIV) && (den_s4 == '0);
		w_c.neg_re  = neg_re_s4;
		w_c.neg_im  = neg_im_s4;
		w_c.sat_re  = {{SH{1'b0}}, nmag_re_s4} >= {den_s4, {SH{1'b0}}};
		w_c.sat_im  = {{SH{1'b0}}, nmag_im_s4} >= {den_s4, {SH{1'b0}}};
		w_c.rem_re  = RW'(nmag_re_s4 >> SH);
		w_c.rem_im  = RW'(nmag_im_s4 >> SH);
		w_c.feed_re = {nmag_re_s4[SH-1:0], {FRAC_BITS{1'b0}}};
		w_c.feed_im = {nmag_im_s4[SH-1:0], {FRAC_BITS{1'b0}}};
		w_c.q_re    = '0;
		w_c.q_im    = '0;
		w_c.den     = den_s4;
		w_c.sq_op   = s_s4;
		w_c.sq_res  = '0;
		w_c.s_hi    = s_s4[PW-1:FRAC_BITS];
		unique case (cmd_s4)
			CMD_ADD, CMD_SUB: begin
				w_c.e_re  = as_re_s4.word;
				w_c.e_im  = as_im_s4.word;
				w_c.e_ovf = as_re_s4.ovf | as_im_s4.ovf;
			end
			CMD_MUL: begin
				w_c.e_re  = mul_re_s4.word;
				w_c.e_im  = mul_im_s4.word;
				w_c.e_ovf = mul_re_s4.ovf | mul_im_s4.ovf;
			end
			default: begin
				w_c.e_re  = '0;
				w_c.e_im  = '0;
				w_c.e_ovf = 1'b0;
			end
		endcase
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1   <= cmd_t'(in_cmd);
			ar_s1    <= in_a_re;
			ai_s1    <= in_a_im;
			br_s1    <= in_b_re;
			bi_s1    <= in_b_im;
			as_re_s1 <= as_re_c;
			as_im_s1 <= as_im_c;

			cmd_s2   <= cmd_s1;
			as_re_s2 <= as_re_s1;
			as_im_s2 <= as_im_s1;
			p_rr_s2  <= ar_s1 * br_s1;
			p_ii_s2  <= ai_s1 * bi_s1;
			p_ri_s2  <= ar_s1 * bi_s1;
			p_ir_s2  <= ai_s1 * br_s1;
			q_br_s2  <= br_s1 * br_s1;
			q_bi_s2  <= bi_s1 * bi_s1;
			q_ar_s2  <= ar_s1 * ar_s1;
			q_ai_s2  <= ai_s1 * ai_s1;

			cmd_s3   <= cmd_s2;
			as_re_s3 <= as_re_s2;
			as_im_s3 <= as_im_s2;
			m_re_s3  <= {p_rr_s2[PW-1], p_rr_s2} - {p_ii_s2[PW-1], p_ii_s2};
			m_im_s3  <= {p_ri_s2[PW-1], p_ri_s2} + {p_ir_s2[PW-1], p_ir_s2};
			n_re_s3  <= {p_rr_s2[PW-1], p_rr_s2} + {p_ii_s2[PW-1], p_ii_s2};
			n_im_s3  <= {p_ir_s2[PW-1], p_ir_s2} - {p_ri_s2[PW-1], p_ri_s2};
			den_s3   <= $unsigned(q_br_s2) + $unsigned(q_bi_s2);
			s_s3     <= $unsigned(q_ar_s2) + $unsigned(q_ai_s2);

			cmd_s4     <= cmd_s3;
			as_re_s4   <= as_re_s3;
			as_im_s4   <= as_im_s3;
			mul_re_s4  <= sat_mag(m_re_s3[SW-1], mag_m_re >> FRAC_BITS);
			mul_im_s4  <= sat_mag(m_im_s3[SW-1], mag_m_im >> FRAC_BITS);
			nmag_re_s4 <= mag_n_re[PW-1:0];
			nmag_im_s4 <= mag_n_im[PW-1:0];
			neg_re_s4  <= n_re_s3[SW-1];
			neg_im_s4  <= n_im_s3[SW-1];
			den_s4     <= den_s3;
			s_s4       <= s_s3;

			w_s5 <= w_c;
		end
	end

	assign out_valid = v_s5;
	assign out_word  = w_s5;

endmodule
`default_nettype wire

// File: src/cau_iter.sv
// unrolled divider and square root: one quotient bit and one root bit per stage
`default_nettype none
module cau_iter (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire cau_pkg::iter_t in_word,
	output logic                out_valid,
	output cau_pkg::iter_t      out_word
);
	import cau_pkg::*;

	localparam int DW = DATA_WIDTH;

	logic [DW:0] vld;
	iter_t       pipe [DW+1];

	assign vld[0]  = in_valid;
	assign pipe[0] = in_word;

	for (genvar k = 0; k < DW; k++) begin : g_stage
		localparam logic [PW-1:0] ONE = {{(PW-1){1'b0}}, 1'b1} << (2 * (DW - 1 - k));

		iter_t         nxt;
		logic [RW-1:0] r_re, r_im;
		logic [PW-1:0] trial;

		// one restoring step for each divider and for the root
		always_comb begin
			nxt  = pipe[k];
			r_re = {pipe[k].rem_re[RW-2:0], pipe[k].feed_re[DW-1]};
			r_im = {pipe[k].rem_im[RW-2:0], pipe[k].feed_im[DW-1]};
			nxt.feed_re = pipe[k].feed_re << 1;
			nxt.feed_im = pipe[k].feed_im << 1;
			if (r_re >= {1'b0, pipe[k].den}) begin
				nxt.rem_re = r_re - {1'b0, pipe[k].den};
				nxt.q_re   = {pipe[k].q_re[DW-2:0], 1'b1};
			end else begin
				nxt.rem_re = r_re;
				nxt.q_re   = {pipe[k].q_re[DW-2:0], 1'b0};
			end
			if (r_im >= {1'b0, pipe[k].den}) begin
				nxt.rem_im = r_im - {1'b0, pipe[k].den};
				nxt.q_im   = {pipe[k].q_im[DW-2:0], 1'b1};
			end else begin
				nxt.rem_im = r_im;
				nxt.q_im   = {pipe[k].q_im[DW-2:0], 1'b0};
			end
			trial = pipe[k].sq_res + ONE;
			if (pipe[k].sq_op >= trial) begin
				nxt.sq_op  = pipe[k].sq_op - trial;
				nxt.sq_res = (pipe[k].sq_res >> 1) + ONE;
			end else begin
				nxt.sq_res = pipe[k].sq_res >> 1;
			end
		end

		// stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end

		// stage payload
		always_ff @(posedge clk) begin
			if (en) begin
				pipe[k+1] <= nxt;
			end
		end
	end

	assign out_valid = vld[DW];
	assign out_word  = pipe[DW];

endmodule
`default_nettype wire

// File: src/cau_back.sv
// final select and saturation into the output register
`default_nettype none
module cau_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire logic                            in_valid,
	input  wire cau_pkg::iter_t                  in_word,
	output logic                                 out_valid,
	output logic [cau_pkg::DATA_WIDTH-1:0]       out_re,
	output logic [cau_pkg::DATA_WIDTH-1:0]       out_im,
	output logic                                 out_ovf,
	output logic                                 out_dz
);
	import cau_pkg::*;

	logic                  v_q;
	logic [DATA_WIDTH-1:0] re_q, im_q;
	logic                  ovf_q, dz_q;

	sat_t                  s_re, s_im;
	logic [DATA_WIDTH-1:0] re_c, im_c;
	logic                  ovf_c;

	// pick the result source by command
	always_comb begin
		s_re = '0;
		s_im = '0;
		re_c = in_word.e_re;
		im_c = in_word.e_im;
		ovf_c = in_word.e_ovf;
		unique case (in_word.cmd)
			CMD_DIV: begin
				s_re = sat_mag(in_word.neg_re,
					in_word.sat_re ? {SW{1'b1}} : SW'(in_word.q_re));
				s_im = sat_mag(in_word.neg_im,
					in_word.sat_im ? {SW{1'b1}} : SW'(in_word.q_im));
				if (in_word.dz) begin
					re_c  = '0;
					im_c  = '0;
					ovf_c = 1'b0;
				end else begin
					re_c  = s_re.word;
					im_c  = s_im.word;
					ovf_c = s_re.ovf | s_im.ovf;
				end
			end
			CMD_MAG: begin
				s_re  = sat_mag(1'b0, SW'(in_word.sq_res));
				s_im  = sat_mag(1'b0, SW'(in_word.s_hi));
				re_c  = s_re.word;
				im_c  = s_im.word;
				ovf_c = s_re.ovf | s_im.ovf;
			end
			default: begin
				re_c  = in_word.e_re;
				im_c  = in_word.e_im;
				ovf_c = in_word.e_ovf;
			end
		endcase
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (en) begin
			re_q  <= re_c;
			im_q  <= im_c;
			ovf_q <= ovf_c;
			dz_q  <= in_word.dz;
		end
	end

	assign out_valid = v_q;
	assign out_re    = re_q;
	assign out_im    = im_q;
	assign out_ovf   = ovf_q;
	assign out_dz    = dz_q;

endmodule
`default_nettype wire

// File: tb/complex_arithmetic_unit_tb.sv
// self-checking testbench for the complex arithmetic unit
`default_nettype none
module complex_arithmetic_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cau_pkg::*;

	// command codes that the unit answers with zeros
	localparam logic [CMD_W-1:0] CMD_RSV5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSV6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSV7 = 3'd7;

	localparam logic [DATA_WIDTH-1:0] ONE_Q   = 32'h0001_0000;
	localparam logic [DATA_WIDTH-1:0] RAW_ONE = 32'h0000_0001;
	localparam logic [DATA_WIDTH-1:0] RAW_M1  = 32'hFFFF_FFFF;
	localparam logic [DATA_WIDTH-1:0] ZERO_W  = 32'h0;
	localparam int LATENCY = 38;

	typedef struct {
		logic [CMD_W-1:0]      cmd;
		logic [DATA_WIDTH-1:0] ar, ai, br, bi;
	} op_word_t;

	typedef struct {
		logic [DATA_WIDTH-1:0] re, im;
		logic                  ovf, dz;
	} res_word_t;

	typedef struct {
		op_word_t  op;
		bit        typed;
		res_word_t want;
	} vec_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cau_in_if  in_ch ();
	cau_out_if out_ch ();

	complex_arithmetic_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #10 clk = ~clk;

	res_word_t pending_q[$];
	vec_row_t  vec_rows[$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_ovf = 0;
	int n_dz = 0;
	int cmd_seen[8];
	int src_idle_pct = 0;
	int snk_stall_pct = 0;

	// saturate an exact value to the word range, ovf in the top bit
	function automatic logic [DATA_WIDTH:0] clamp_word(input logic signed [127:0] v);
		logic signed [127:0] hi, lo;
		hi = 128'sh7FFF_FFFF;
		lo = -128'sh8000_0000;
		if (v > hi) return {1'b1, WORD_MAX};
		if (v < lo) return {1'b1, WORD_MIN};
		return {1'b0, v[DATA_WIDTH-1:0]};
	endfunction

	// drop the fraction bits, rounding toward zero
	function automatic logic signed [127:0] drop_frac(input logic signed [127:0] v);
		if (v < 0) return -((-v) >>> FRAC_BITS);
		return v >>> FRAC_BITS;
	endfunction

	// exact quotient of num * 2^frac over den, toward zero
	function automatic logic signed [127:0] frac_quot(input logic signed [127:0] num,
			input logic [127:0] den);
		logic [127:0] q;
		q = (((num < 0) ? -num : num) << FRAC_BITS) / den;
		return (num < 0) ? -$signed(q) : $signed(q);
	endfunction

	// expected result of one operation word
	function automatic res_word_t complex_result(input op_word_t w);
		logic signed [127:0] ar, ai, br, bi, re, im;
		logic [127:0] den, sq, cand, root;
		logic [DATA_WIDTH:0] sre, sim;
		res_word_t r;
		ar = $signed(w.ar);
		ai = $signed(w.ai);
		br = $signed(w.br);
		bi = $signed(w.bi);
		r = '{re: '0, im: '0, ovf: 1'b0, dz: 1'b0};
		re = 0;
		im = 0;
		case (w.cmd)
			CMD_ADD: begin
				re = ar + br;
				im = ai + bi;
			end
			CMD_SUB: begin
				re = ar - br;
				im = ai - bi;
			end
			CMD_MUL: begin
				re = drop_frac(ar * br - ai * bi);
				im = drop_frac(ar * bi + ai * br);
			end
			CMD_DIV: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.dz = 1'b1;
					return r;
				end
				re = frac_quot(ar * br + ai * bi, den);
				im = frac_quot(ai * br - ar * bi, den);
			end
			CMD_MAG: begin
				sq = ar * ar + ai * ai;
				root = 0;
				for (int b = 32; b >= 0; b--) begin
					cand = root | (128'd1 << b);
					if (cand * cand <= sq) root = cand;
				end
				re = $signed(root);
				im = $signed(sq >> FRAC_BITS);
			end
			default: return r;
		endcase
		sre = clamp_word(re);
		sim = clamp_word(im);
		r.re = sre[DATA_WIDTH-1:0];
		r.im = sim[DATA_WIDTH-1:0];
		r.ovf = sre[DATA_WIDTH] | sim[DATA_WIDTH];
		return r;
	endfunction

	// one line per wrong field, counted
	task automatic report_mismatch(input string field, input logic [DATA_WIDTH-1:0] got,
			input logic [DATA_WIDTH-1:0] want);
		errors++;
		$display("mismatch on result %0d: %s got %h want %h", n_checked, field, got, want);
	endtask

	task automatic add_row(input logic [CMD_W-1:0] c, input logic [DATA_WIDTH-1:0] ar,
			input logic [DATA_WIDTH-1:0] ai, input logic [DATA_WIDTH-1:0] br,
			input logic [DATA_WIDTH-1:0] bi, input bit typed,
			input logic [DATA_WIDTH-1:0] re, input logic [DATA_WIDTH-1:0] im,
			input logic ovf, input logic dz);
		vec_row_t v;
		v.op = '{cmd: c, ar: ar, ai: ai, br: br, bi: bi};
		v.typed = typed;
		v.want = '{re: re, im: im, ovf: ovf, dz: dz};
		vec_rows.push_back(v);
	endtask

	// present one word and hold it until the handshake
	task automatic push_word(input op_word_t w, input bit typed, input res_word_t want);
		bit done;
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= w.cmd;
		in_ch.a_re <= w.ar;
		in_ch.a_im <= w.ai;
		in_ch.b_re <= w.br;
		in_ch.b_im <= w.bi;
		done = 1'b0;
		while (!done) begin
			@(negedge clk);
			done = in_ch.ready;
			@(posedge clk);
		end
		pending_q.push_back(typed ? want : complex_result(w));
		cmd_seen[w.cmd]++;
		n_sent++;
	endtask

	// random operand part, biased toward corners and small values
	function automatic logic [DATA_WIDTH-1:0] rand_part();
		case ($urandom_range(9))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return ZERO_W;
			3: return $urandom_range(1) ? RAW_ONE : RAW_M1;
			4, 5: return $urandom_range(1) ? $urandom_range(32'h000F_FFFF)
					: -$urandom_range(32'h000F_FFFF);
			default: return $urandom;
		endcase
	endfunction

	function automatic op_word_t rand_word();
		op_word_t w;
		w.cmd = ($urandom_range(19) == 0) ? CMD_W'(CMD_RSV5 + $urandom_range(2))
				: CMD_W'($urandom_range(CMD_MAG));
		w.ar = rand_part();
		w.ai = rand_part();
		w.br = rand_part();
		w.bi = rand_part();
		if (w.cmd == CMD_DIV && $urandom_range(9) == 0) begin
			w.br = ZERO_W;
			w.bi = ZERO_W;
		end
		return w;
	endfunction

	// result side: random backpressure
	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// compare each accepted result word with the oldest expectation
	always @(negedge clk) begin
		res_word_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_q.size() == 0) begin
				errors++;
				$display("unexpected result word %h %h", out_ch.res_re, out_ch.res_im);
			end else begin
				want = pending_q.pop_front();
				if (out_ch.res_re !== want.re) report_mismatch("res_re", out_ch.res_re, want.re);
				if (out_ch.res_im !== want.im) report_mismatch("res_im", out_ch.res_im, want.im);
				if (out_ch.overflow !== want.ovf)
					report_mismatch("overflow", DATA_WIDTH'(out_ch.overflow),
						DATA_WIDTH'(want.ovf));
				if (out_ch.div_by_zero !== want.dz)
					report_mismatch("div_by_zero", DATA_WIDTH'(out_ch.div_by_zero),
						DATA_WIDTH'(want.dz));
				n_ovf += want.ovf;
				n_dz += want.dz;
			end
			n_checked++;
		end
	end

	// hard stop
	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		res_word_t none;
		int waited;
		none = '{re: '0, im: '0, ovf: 1'b0, dz: 1'b0};
		in_ch.valid = 1'b0;
		in_ch.cmd = '0;
		in_ch.a_re = '0;
		in_ch.a_im = '0;
		in_ch.b_re = '0;
		in_ch.b_im = '0;
		out_ch.ready = 1'b0;

		// directed corners
		add_row(CMD_ADD, ZERO_W, ZERO_W, ZERO_W, ZERO_W, 1, ZERO_W, ZERO_W, 0, 0);
		add_row(CMD_ADD, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1, WORD_MAX, WORD_MAX, 1, 0);
		add_row(CMD_ADD, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1, WORD_MIN, WORD_MIN, 1, 0);
		add_row(CMD_ADD, WORD_MAX, WORD_MIN, RAW_M1, RAW_ONE, 0, '0, '0, 0, 0);
		add_row(CMD_SUB, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN, 1, WORD_MIN, WORD_MAX, 1, 0);
		add_row(CMD_SUB, ONE_Q, RAW_M1, RAW_M1, ONE_Q, 0, '0, '0, 0, 0);
		add_row(CMD_MUL, ONE_Q, ZERO_W, ONE_Q, ZERO_W, 0, '0, '0, 0, 0);
		add_row(CMD_MUL, WORD_MIN, ZERO_W, WORD_MIN, ZERO_W, 1, WORD_MAX, ZERO_W, 1, 0);
		add_row(CMD_MUL, RAW_M1, RAW_ONE, RAW_ONE, RAW_M1, 0, '0, '0, 0, 0);
		add_row(CMD_MUL, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, 0, '0, '0, 0, 0);
		add_row(CMD_DIV, ONE_Q, ONE_Q, ZERO_W, ZERO_W, 1, ZERO_W, ZERO_W, 0, 1);
		add_row(CMD_DIV, ZERO_W, ZERO_W, ZERO_W, ZERO_W, 1, ZERO_W, ZERO_W, 0, 1);
		add_row(CMD_DIV, ONE_Q, ZERO_W, ONE_Q, ZERO_W, 0, '0, '0, 0, 0);
		add_row(CMD_DIV, WORD_MAX, WORD_MIN, RAW_ONE, ZERO_W, 0, '0, '0, 0, 0);
		add_row(CMD_DIV, WORD_MIN, RAW_ONE, RAW_M1, RAW_M1, 0, '0, '0, 0, 0);
		add_row(CMD_DIV, RAW_M1, ONE_Q, 32'h0003_0000, WORD_MIN, 0, '0, '0, 0, 0);
		add_row(CMD_MAG, ZERO_W, ZERO_W, WORD_MAX, WORD_MIN, 1, ZERO_W, ZERO_W, 0, 0);
		add_row(CMD_MAG, WORD_MIN, WORD_MIN, ZERO_W, ZERO_W, 1, WORD_MAX, WORD_MAX, 1, 0);
		add_row(CMD_MAG, 32'h0003_0000, 32'hFFFC_0000, ONE_Q, ONE_Q, 0, '0, '0, 0, 0);
		add_row(CMD_MAG, RAW_M1, RAW_ONE, ZERO_W, ZERO_W, 0, '0, '0, 0, 0);
		add_row(CMD_RSV5, WORD_MAX, WORD_MIN, RAW_ONE, RAW_M1, 1, ZERO_W, ZERO_W, 0, 0);
		add_row(CMD_RSV6, ONE_Q, ONE_Q, ZERO_W, ZERO_W, 1, ZERO_W, ZERO_W, 0, 0);
		add_row(CMD_RSV7, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN, 1, ZERO_W, ZERO_W, 0, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		foreach (vec_rows[i]) push_word(vec_rows[i].op, vec_rows[i].typed, vec_rows[i].want);

		// hold off until the pipe drains
		in_ch.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);

		// random words in three idling phases
		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 76 : 0;
			snk_stall_pct = (ph == 0) ? 76 : (ph == 1) ? 35 : 0;
			for (int k = 0; k < 200; k++) push_word(rand_word(), 0, none);
		end
		in_ch.valid <= 1'b0;
		snk_stall_pct = 0;

		waited = 0;
		while (pending_q.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (2 * LATENCY) @(posedge clk);
		if (pending_q.size() != 0) begin
			errors++;
			$display("%0d result words never arrived", pending_q.size());
		end

		$display("sent %0d words (add %0d sub %0d mul %0d div %0d mag %0d other %0d)",
				n_sent, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], cmd_seen[4],
				cmd_seen[5] + cmd_seen[6] + cmd_seen[7]);
		$display("checked %0d results, %0d saturated, %0d zero divisors, %0d errors",
				n_checked, n_ovf, n_dz, errors);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
`default_nettype wire

// File: filelist.f
src/cau_pkg.sv
src/cau_in_if.sv
src/cau_out_if.sv
src/cau_front.sv
src/cau_iter.sv
src/cau_back.sv
src/complex_arithmetic_unit.sv
tb/complex_arithmetic_unit_tb.sv
